FILE: design/tsteol_pkg.sv
// Shared types, character codes and command format for the trailing space trimmer.
package tsteol_pkg;

    // Default depth of the held whitespace store.
    localparam int HOLD_DEPTH_DEF = 32;

    // Depth of the command queue between the front and the back (power of two).
    localparam int QUEUE_DEPTH = 4;

    // Character codes.
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_VT  = 8'd11;
    localparam logic [7:0] CH_FF  = 8'd12;

    // Line ending modes.
    localparam logic [1:0] MODE_KEEP = 2'd0;
    localparam logic [1:0] MODE_LF   = 2'd1;
    localparam logic [1:0] MODE_CRLF = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CR_ERR   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Work the back performs for one request.
    typedef enum logic [1:0] {
        OP_HOLD,   // store one whitespace byte
        OP_SPILL,  // emit the oldest held byte, then store a new one in its slot
        OP_FLUSH,  // emit the held run, then the byte that ended it
        OP_LINE    // emit CR and or LF, or one empty result
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       cr;
        logic       lf;
        logic       chg;
        logic [1:0] status;
        logic [7:0] data;
    } cmd_t;

endpackage

FILE: design/tsteol_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tsteol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tsteol_pkg::HOLD_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: design/tsteol_fifo.sv
// Short request queue between the front and the back.
module tsteol_fifo #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             not_empty
);
    import tsteol_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slots [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      fill_reg;

    assign full      = (fill_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign dout      = slots[rd_ptr_reg];

    // Payload slots need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= din;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (PW+1)'(1);
            end
        end
    end
endmodule

FILE: design/tsteol_front.sv
// Front end: accepts bytes, tracks line state and issues requests to the back.
module tsteol_front #(
    parameter int HOLD_DEPTH = tsteol_pkg::HOLD_DEPTH_DEF,
    parameter int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1,
    parameter int CW = $clog2(HOLD_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                end_of_stream,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    output logic                cmd_push,
    output tsteol_pkg::cmd_t    cmd,
    output logic [AW-1:0]       cmd_addr,
    output logic [CW-1:0]       cmd_n,
    input  logic                q_full
);
    import tsteol_pkg::*;

    logic [1:0]    eol_mode_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          cr_seen_reg, cr_seen_next;
    logic          line_open_reg, line_open_next;
    logic          any_change_reg, any_change_next;
    logic          halted_reg, halted_next;

    logic          accept;
    logic          is_ws;
    logic          mode_keep;
    logic          mode_crlf;
    logic          eol_crlf;
    logic          end_break;
    logic          store_full;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    assign is_ws = (in_byte == CH_SP) || (in_byte == CH_TAB) ||
                   (in_byte == CH_VT) || (in_byte == CH_FF);

    // The undefined mode code behaves as LF.
    assign mode_keep = (eol_mode_reg == MODE_KEEP);
    assign mode_crlf = (eol_mode_reg == MODE_CRLF);

    // Outgoing line end form; the source form is CR LF exactly when a CR is pending.
    assign eol_crlf  = mode_keep ? cr_seen_reg : mode_crlf;
    assign end_break = line_open_reg && !mode_keep;

    assign store_full = (count_reg == CW'(HOLD_DEPTH));
    assign head_inc   = (head_reg == AW'(HOLD_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_inc   = (tail_reg == AW'(HOLD_DEPTH - 1)) ? '0 : tail_reg + AW'(1);

    // Classify the byte and work out the request and the next line state.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        cr_seen_next    = cr_seen_reg;
        line_open_next  = line_open_reg;
        any_change_next = any_change_reg;
        halted_next     = halted_reg;
        cmd_push        = 1'b0;
        cmd             = '{op: OP_LINE, cr: 1'b0, lf: 1'b0, chg: 1'b0,
                            status: ST_OK, data: in_byte};
        cmd_addr        = head_reg;
        cmd_n           = count_reg;

        if (accept)
        begin
            if (end_of_stream)
            begin
                cmd_push = 1'b1;
                if (halted_reg || cr_seen_reg)
                begin
                    cmd.status = ST_CR_ERR;
                    cmd.chg    = any_change_reg;
                end
                else
                begin
                    cmd.cr  = end_break && mode_crlf;
                    cmd.lf  = end_break;
                    cmd.chg = any_change_reg || (count_reg != '0) || end_break;
                end
                // Start over for the next stream.
                head_next       = tail_reg;
                count_next      = '0;
                cr_seen_next    = 1'b0;
                line_open_next  = 1'b0;
                any_change_next = 1'b0;
                halted_next     = 1'b0;
            end
            else if (!halted_reg)
            begin
                if (cr_seen_reg || (in_byte == CH_LF))
                begin
                    cr_seen_next = 1'b0;
                    head_next    = tail_reg;
                    count_next   = '0;
                    cmd_push     = 1'b1;
                    if (in_byte == CH_LF)
                    begin
                        // Line end; held whitespace is trimmed.
                        cmd.cr          = eol_crlf;
                        cmd.lf          = 1'b1;
                        line_open_next  = 1'b0;
                        any_change_next = any_change_reg || (count_reg != '0) ||
                                          (eol_crlf != cr_seen_reg);
                    end
                    else
                    begin
                        // A CR without LF halts the stream.
                        cmd.status  = ST_CR_ERR;
                        halted_next = 1'b1;
                    end
                end
                else if (in_byte == CH_CR)
                begin
                    cr_seen_next   = 1'b1;
                    line_open_next = 1'b1;
                end
                else if (is_ws)
                begin
                    line_open_next = 1'b1;
                    cmd_push       = 1'b1;
                    tail_next      = tail_inc;
                    if (store_full)
                    begin
                        // The store is full: the oldest byte goes out, its slot is reused.
                        cmd.op    = OP_SPILL;
                        cmd_addr  = head_reg;
                        head_next = head_inc;
                    end
                    else
                    begin
                        cmd.op     = OP_HOLD;
                        cmd_addr   = tail_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                else
                begin
                    // Ordinary byte releases the held run.
                    line_open_next = 1'b1;
                    cmd_push       = 1'b1;
                    cmd.op         = OP_FLUSH;
                    head_next      = tail_reg;
                    count_next     = '0;
                end
            end
        end
    end

    // Line state and the mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eol_mode_reg   <= MODE_LF;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            cr_seen_reg    <= 1'b0;
            line_open_reg  <= 1'b0;
            any_change_reg <= 1'b0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                eol_mode_reg <= cfg_data;
            end
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            cr_seen_reg    <= cr_seen_next;
            line_open_reg  <= line_open_next;
            any_change_reg <= any_change_next;
            halted_reg     <= halted_next;
        end
    end
endmodule

FILE: design/tsteol_back.sv
// Back end: carries out queued requests, reads the whitespace store and drives results.
module tsteol_back #(
    parameter int HOLD_DEPTH = tsteol_pkg::HOLD_DEPTH_DEF,
    parameter int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1,
    parameter int CW = $clog2(HOLD_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  tsteol_pkg::cmd_t q_cmd,
    input  logic [AW-1:0]    q_addr,
    input  logic [CW-1:0]    q_n,
    output logic             q_pop,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [7:0]       ram_wdata,
    output logic             ram_re,
    output logic [AW-1:0]    ram_raddr,
    input  logic [7:0]       ram_rdata,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             last,
    output logic             changed,
    output logic [1:0]       status
);
    import tsteol_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HELD,
        S_CR,
        S_LAST
    } state_t;

    state_t        state_reg;
    cmd_t          cur_reg;
    logic [AW-1:0] cur_addr_reg;
    logic [AW-1:0] addr_reg;
    logic [CW-1:0] left_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          last_reg;
    logic          changed_reg;
    logic [1:0]    status_reg;

    logic          out_free;
    logic          out_load;
    logic          is_spill;
    logic [AW-1:0] q_addr_inc;
    logic [AW-1:0] addr_inc;

    assign out_free   = !out_valid_reg || out_ready;
    assign is_spill   = (cur_reg.op == OP_SPILL);
    assign q_addr_inc = (q_addr == AW'(HOLD_DEPTH - 1)) ? '0 : q_addr + AW'(1);
    assign addr_inc   = (addr_reg == AW'(HOLD_DEPTH - 1)) ? '0 : addr_reg + AW'(1);

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign last       = last_reg;
    assign changed    = changed_reg;
    assign status     = status_reg;

    // Queue pop, store access and output load for the current step.
    always_comb
    begin
        q_pop     = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = q_addr;
        ram_wdata = q_cmd.data;
        ram_re    = 1'b0;
        ram_raddr = q_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_HOLD:  ram_we = 1'b1;
                        OP_SPILL: ram_re = 1'b1;
                        OP_FLUSH: ram_re = (q_n != '0);
                        default:  ram_re = 1'b0;
                    endcase
                end
            end
            S_HELD:
            begin
                out_load = out_free;
                if (out_free)
                begin
                    if (left_reg != '0)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_reg;
                    end
                    else if (is_spill)
                    begin
                        // The slot just read now takes the new whitespace byte.
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr_reg;
                        ram_wdata = cur_reg.data;
                    end
                end
            end
            S_CR, S_LAST:
            begin
                out_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Sequencer state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            cur_reg        <= '{op: OP_HOLD, cr: 1'b0, lf: 1'b0, chg: 1'b0,
                                status: ST_OK, data: 8'd0};
            cur_addr_reg   <= '0;
            addr_reg       <= '0;
            left_reg       <= '0;
            out_byte_reg   <= 8'd0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            changed_reg    <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            // A result stays until taken; a new one loads when the register is free.
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg      <= q_cmd;
                        cur_addr_reg <= q_addr;
                        addr_reg     <= q_addr_inc;
                        left_reg     <= ((q_cmd.op == OP_FLUSH) && (q_n != '0)) ?
                                        q_n - CW'(1) : '0;
                        case (q_cmd.op)
                            OP_HOLD:  state_reg <= S_IDLE;
                            OP_SPILL: state_reg <= S_HELD;
                            OP_FLUSH:
                            begin
                                if (q_n != '0)
                                begin
                                    state_reg <= S_HELD;
                                end
                                else
                                begin
                                    state_reg <= S_LAST;
                                end
                            end
                            default:  state_reg <= q_cmd.cr ? S_CR : S_LAST;
                        endcase
                    end
                end
                S_HELD:
                begin
                    // The read data holds one held byte.
                    if (out_free)
                    begin
                        out_byte_reg   <= ram_rdata;
                        byte_valid_reg <= 1'b1;
                        last_reg       <= is_spill;
                        changed_reg    <= 1'b0;
                        status_reg     <= is_spill ? ST_OVERFLOW : ST_OK;
                        if (left_reg != '0)
                        begin
                            left_reg <= left_reg - CW'(1);
                            addr_reg <= addr_inc;
                        end
                        else
                        begin
                            state_reg <= is_spill ? S_IDLE : S_LAST;
                        end
                    end
                end
                S_CR:
                begin
                    if (out_free)
                    begin
                        out_byte_reg   <= CH_CR;
                        byte_valid_reg <= 1'b1;
                        last_reg       <= 1'b0;
                        changed_reg    <= cur_reg.chg;
                        status_reg     <= cur_reg.status;
                        state_reg      <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    if (out_free)
                    begin
                        last_reg      <= 1'b1;
                        changed_reg   <= cur_reg.chg;
                        status_reg    <= cur_reg.status;
                        if (cur_reg.op == OP_FLUSH)
                        begin
                            out_byte_reg   <= cur_reg.data;
                            byte_valid_reg <= 1'b1;
                        end
                        else if (cur_reg.lf)
                        begin
                            out_byte_reg   <= CH_LF;
                            byte_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            out_byte_reg   <= 8'd0;
                            byte_valid_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: design/trailing_space_trim_eol_convert_top.sv
// Trailing whitespace trimmer with line ending conversion: top level.
// Path: a request passes the queue, then the back's request register, then the output register.
// Throughput: the front takes one byte a cycle while the four-entry queue has room; the back
// finishes each request before it pops the next, reading released bytes one at a time through
// the single read port of the whitespace store; a line end sends CR, if due, before LF.
// Reset (rst_n, asynchronous): clears line state and queue, line mode returns to LF; no clearing pass.
module trailing_space_trim_eol_convert_top #(
    parameter int HOLD_DEPTH = tsteol_pkg::HOLD_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last,
    output logic       changed,
    output logic [1:0] status
);
    import tsteol_pkg::*;

    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int CMD_W = $bits(cmd_t);
    localparam int QW = CMD_W + AW + CW;

    logic          cmd_push;
    cmd_t          cmd;
    logic [AW-1:0] cmd_addr;
    logic [CW-1:0] cmd_n;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [QW-1:0] q_dout;
    cmd_t          q_cmd;
    logic [AW-1:0] q_addr;
    logic [CW-1:0] q_n;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    tsteol_front #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .cmd_push      (cmd_push),
        .cmd           (cmd),
        .cmd_addr      (cmd_addr),
        .cmd_n         (cmd_n),
        .q_full        (q_full)
    );

    // Request queue between the two halves.
    tsteol_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .din       ({cmd, cmd_addr, cmd_n}),
        .full      (q_full),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_valid)
    );

    assign q_cmd  = cmd_t'(q_dout[QW-1 -: CMD_W]);
    assign q_addr = q_dout[CW +: AW];
    assign q_n    = q_dout[CW-1:0];

    // Held whitespace store.
    tsteol_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsteol_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_addr     (q_addr),
        .q_n        (q_n),
        .q_pop      (q_pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .changed    (changed),
        .status     (status)
    );
endmodule

FILE: design/tsteol_checker.sv
// Port level checks for the trimmer top level, with the bind that attaches them.
module tsteol_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       last,
    input logic       changed,
    input logic [1:0] status
);
    import tsteol_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("result changed while stalled");

    // An overflow result carries the spilled byte and ends its request.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OVERFLOW) |-> byte_valid && last && !changed)
        else $error("bad overflow result");

    // A lone CR error is a single empty result.
    a_cr_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_CR_ERR) |-> !byte_valid && last && (out_byte == 8'd0))
        else $error("bad lone CR result");

    // Changed ahead of the final result only marks the CR of a closing break.
    a_changed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed && !last |-> byte_valid && (out_byte == CH_CR))
        else $error("changed flag on unexpected result");

    // A result without a byte carries zero.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> (out_byte == 8'd0) && last)
        else $error("empty result with data");
endmodule

bind trailing_space_trim_eol_convert_top tsteol_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .changed    (changed),
    .status     (status)
);

FILE: bench/tb_trailing_space_trim_eol_convert_top.sv
// Testbench for the trailing whitespace trimmer with line ending conversion.
module tb_trailing_space_trim_eol_convert_top;
    import tsteol_pkg::*;

    localparam int HOLD_DEPTH = HOLD_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS = 260;

    // Unassigned line ending code; the block treats it as LF.
    localparam logic [1:0] MODE_RSVD = 2'd3;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       lst;
        logic       chg;
        logic [1:0] st;
    } out_rec_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'd0;
    logic       end_of_stream = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = 2'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       changed;
    logic [1:0] status;

    // Predicted line state and the bytes still due from the block.
    logic [7:0] held_ws[$];
    bit         cr_pend;
    bit         line_open;
    bit         any_chg;
    bit         halted;
    logic [1:0] eol_mode_m = MODE_LF;
    out_rec_t   pending_out[$];

    int fail_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int burst_left = 0;
    bit gaps_on = 1'b0;
    int rcv_tick = 0;
    int stall_kind = 0;

    trailing_space_trim_eol_convert_top #(.HOLD_DEPTH(HOLD_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_stream(end_of_stream),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .last         (last),
        .changed      (changed),
        .status       (status)
    );

    always #5 clk = ~clk;

    // Builds one result; a result without a byte carries zero data.
    function automatic out_rec_t make_rec(logic [7:0] d, bit v, logic [1:0] s);
        out_rec_t r;
        r.data = v ? d : 8'd0;
        r.bv   = v;
        r.lst  = 1'b0;
        r.chg  = 1'b0;
        r.st   = s;
        return r;
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

    // Writes a line end; src_crlf tells which form arrived.
    task automatic emit_line_end(ref out_rec_t res[$], input bit src_crlf);
        logic [1:0] m;
        bit         crlf;
        m = (eol_mode_m == MODE_RSVD) ? MODE_LF : eol_mode_m;
        crlf = (m == MODE_KEEP) ? src_crlf : (m == MODE_CRLF);
        if (held_ws.size() > 0)
            any_chg = 1'b1;
        held_ws.delete();
        if (crlf != src_crlf)
            any_chg = 1'b1;
        if (crlf)
            res.push_back(make_rec(CH_CR, 1'b1, ST_OK));
        res.push_back(make_rec(CH_LF, 1'b1, ST_OK));
        line_open = 1'b0;
    endtask

    // Works out the results of one accepted request and queues them.
    task automatic trim_predict(input logic [7:0] c, input logic eos);
        out_rec_t   res[$];
        logic [1:0] m;
        logic [1:0] st;
        m = (eol_mode_m == MODE_RSVD) ? MODE_LF : eol_mode_m;
        if (eos)
        begin
            st = ST_OK;
            if (halted || cr_pend)
            begin
                st = ST_CR_ERR;
                held_ws.delete();
            end
            else
            begin
                if (held_ws.size() > 0)
                    any_chg = 1'b1;
                held_ws.delete();
                if (line_open && m != MODE_KEEP)
                begin
                    any_chg = 1'b1;
                    if (m == MODE_CRLF)
                        res.push_back(make_rec(CH_CR, 1'b1, ST_OK));
                    res.push_back(make_rec(CH_LF, 1'b1, ST_OK));
                end
            end
            if (res.size() == 0)
                res.push_back(make_rec(8'd0, 1'b0, st));
            foreach (res[i])
            begin
                res[i].chg = any_chg;
                res[i].st  = st;
            end
            held_ws.delete();
            cr_pend = 1'b0;
            line_open = 1'b0;
            any_chg = 1'b0;
            halted = 1'b0;
        end
        else if (halted)
        begin
            // A halted stream swallows every byte until its end marker.
        end
        else if (cr_pend)
        begin
            cr_pend = 1'b0;
            if (c == CH_LF)
                emit_line_end(res, 1'b1);
            else
            begin
                held_ws.delete();
                halted = 1'b1;
                res.push_back(make_rec(8'd0, 1'b0, ST_CR_ERR));
            end
        end
        else if (c == CH_CR)
        begin
            cr_pend = 1'b1;
            line_open = 1'b1;
        end
        else if (c == CH_LF)
            emit_line_end(res, 1'b0);
        else if (is_ws(c))
        begin
            line_open = 1'b1;
            if (held_ws.size() >= HOLD_DEPTH)
            begin
                res.push_back(make_rec(held_ws[0], 1'b1, ST_OVERFLOW));
                void'(held_ws.pop_front());
            end
            held_ws.push_back(c);
        end
        else
        begin
            line_open = 1'b1;
            foreach (held_ws[i])
                res.push_back(make_rec(held_ws[i], 1'b1, ST_OK));
            held_ws.delete();
            res.push_back(make_rec(c, 1'b1, ST_OK));
        end
        if (res.size() > 0)
            res[res.size() - 1].lst = 1'b1;
        foreach (res[i])
            pending_out.push_back(res[i]);
    endtask

    // Sends one request, idling between bursts when gaps are enabled.
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte <= b;
        end_of_stream <= eos;
        do @(posedge clk); while (!in_ready);
        if (eos || !halted)
            items_sent++;
        trim_predict(b, eos);
        @(negedge clk);
    endtask

    // Drains the block, then writes the line ending mode.
    task automatic write_eol_mode(input logic [1:0] m);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        eol_mode_m = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_ws();
        logic [7:0] ws[4];
        ws = '{CH_SP, CH_TAB, CH_VT, CH_FF};
        return ws[$urandom_range(0, 3)];
    endfunction

    // Mostly printable text, now and then any byte value at all.
    function automatic logic [7:0] pick_text();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    // Plain text with embedded whitespace and the byte value extremes.
    task automatic test_plain_text();
        send_item("a", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_SP, 1'b0);
        send_item(CH_TAB, 1'b0);
        send_item("b", 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // Both line end forms with trailing whitespace in keep mode.
    task automatic test_line_ends();
        send_item("x", 1'b0);
        send_item(CH_SP, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item("y", 1'b0);
        send_item(CH_VT, 1'b0);
        send_item(CH_FF, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    // A CR followed by text halts the stream; a CR before the end marker is an error too.
    task automatic test_lone_cr();
        send_item("z", 1'b0);
        send_item(CH_CR, 1'b0);
        send_item("q", 1'b0);
        send_item("w", 1'b0);
        send_item(8'h5A, 1'b1);
        send_item(CH_CR, 1'b1);
        send_item(CH_CR, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // Open lines and empty streams at the end marker.
    task automatic test_end_of_stream();
        send_item("k", 1'b0);
        send_item(CH_SP, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h55, 1'b1);
    endtask

    // A whitespace run longer than the store spills its oldest bytes.
    task automatic test_store_overflow();
        int run;
        run = HOLD_DEPTH + $urandom_range(1, 8);
        send_item("a", 1'b0);
        repeat (run) send_item(pick_ws(), 1'b0);
        send_item("b", 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Random streams: lines of words and whitespace runs, some noise, several modes.
    task automatic test_random_streams();
        int phase;
        int start;
        int lines;
        int words;
        int run;
        phase = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            write_eol_mode(phase < 4 ? 2'(phase) : 2'($urandom_range(0, 3)));
            gaps_on = ($urandom_range(0, 3) != 0);
            phase++;
            repeat ($urandom_range(1, 3))
            begin
                lines = $urandom_range(0, 4);
                repeat (lines)
                begin
                    words = $urandom_range(0, 3);
                    repeat (words)
                    begin
                        repeat ($urandom_range(1, 5)) send_item(pick_text(), 1'b0);
                        if ($urandom_range(0, 19) == 0)
                            run = $urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 4);
                        else
                            run = $urandom_range(0, 3);
                        repeat (run) send_item(pick_ws(), 1'b0);
                    end
                    case ($urandom_range(0, 9))
                        0: send_item(CH_CR, 1'b0);
                        1, 2, 3:
                        begin
                            send_item(CH_CR, 1'b0);
                            send_item(CH_LF, 1'b0);
                        end
                        4:
                        begin
                            // The line runs on without a break.
                        end
                        default: send_item(CH_LF, 1'b0);
                    endcase
                end
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    // Receiver stall pattern: always ready, random, periodic or heavy back pressure.
    always @(negedge clk)
    begin
        rcv_tick = rcv_tick + 1;
        if (rcv_tick % 256 == 0)
            stall_kind = $urandom_range(0, 3);
        case (stall_kind)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ((rcv_tick % 7) < 3);
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Compare each delivered result with the oldest prediction.
    always @(posedge clk)
    begin
        out_rec_t got;
        out_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_byte, byte_valid, last, changed, status};
            if (pending_out.size() == 0)
            begin
                $display("%0t: unexpected result: byte %02h valid %0b last %0b chg %0b st %0d",
                         $time, got.data, got.bv, got.lst, got.chg, got.st);
                fail_count++;
            end
            else
            begin
                want = pending_out.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch: expected byte %02h valid %0b last %0b chg %0b st %0d",
                             $time, want.data, want.bv, want.lst, want.chg, want.st);
                    $display("%0t:           actual   byte %02h valid %0b last %0b chg %0b st %0d",
                             $time, got.data, got.bv, got.lst, got.chg, got.st);
                    fail_count++;
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset mode is LF; the directed tests before the store overflow test run without sender gaps.
        test_plain_text();
        write_eol_mode(MODE_KEEP);
        test_line_ends();
        write_eol_mode(MODE_CRLF);
        test_lone_cr();
        write_eol_mode(MODE_RSVD);
        test_end_of_stream();
        write_eol_mode(MODE_KEEP);
        test_end_of_stream();
        gaps_on = 1'b1;
        write_eol_mode(MODE_CRLF);
        test_store_overflow();
        test_random_streams();

        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
